[rtl/owbm_pkg.sv]
// ----------------------------------------------------------------------------
// owbm_pkg
// Shared widths, register map and reset values for the 1-Wire bus master.
// ----------------------------------------------------------------------------
package owbm_pkg;

  localparam int TickW   = 10;
  localparam int ByteW   = 8;
  localparam int ActionW = 2;
  localparam int NumRegs = 8;
  localparam int RegIdxW = $clog2(NumRegs);
  localparam int AddrW   = RegIdxW + 2;
  localparam int DataW   = 32;

  typedef logic [TickW-1:0]   tick_t;
  typedef logic [ActionW-1:0] action_t;
  typedef logic [ByteW-1:0]   byte_t;

  // Command codes
  localparam action_t ActTick  = 2'd0;
  localparam action_t ActReset = 2'd1;
  localparam action_t ActWrite = 2'd2;
  localparam action_t ActRead  = 2'd3;

  // Register indexes
  localparam logic [RegIdxW-1:0] RegResetLow    = 3'd0;
  localparam logic [RegIdxW-1:0] RegPresWait    = 3'd1;
  localparam logic [RegIdxW-1:0] RegResetTail   = 3'd2;
  localparam logic [RegIdxW-1:0] RegSlotLow     = 3'd3;
  localparam logic [RegIdxW-1:0] RegSlotHold    = 3'd4;
  localparam logic [RegIdxW-1:0] RegReadLow     = 3'd5;
  localparam logic [RegIdxW-1:0] RegReadSample  = 3'd6;
  localparam logic [RegIdxW-1:0] RegRecovery    = 3'd7;

  localparam tick_t RegResetVal [NumRegs] = '{
    10'd500, 10'd70, 10'd500, 10'd10, 10'd50, 10'd2, 10'd10, 10'd50
  };

  // A zero register acts as a one-tick phase.
  function automatic tick_t eff_ticks(input tick_t v);
    eff_ticks = (v == '0) ? tick_t'(1) : v;
  endfunction

endpackage

[rtl/one_wire_bus_master.sv]
// ----------------------------------------------------------------------------
// one_wire_bus_master
// 1-Wire master stepped one tick per input beat: bus reset with presence
// detect, byte write and byte read, LSB first, with programmable slot timing.
// ----------------------------------------------------------------------------
// The result for a tick beat is registered: it appears in the output register in the
// cycle after the beat is accepted. Throughput: one tick beat per cycle unless stalled; the
// sequencer state (phase, tick and bit counters, shift register) updates once
// per accepted beat. Input stalls only while a result is held and stalled.
// Reset (rst, synchronous) returns the sequencer to idle, clears presence and
// read data, and loads the timing registers with their default values.
module one_wire_bus_master (
  input  logic                     clk,
  input  logic                     rst,
  // tick input channel
  input  logic                     in_valid,
  output logic                     in_stall,
  input  owbm_pkg::action_t        action,
  input  owbm_pkg::byte_t          write_byte,
  input  logic                     line_level,
  // result channel
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     drive_low,
  output logic                     busy_res,
  output logic                     done_res,
  output logic                     presence_seen,
  output owbm_pkg::byte_t          read_data,
  output logic                     rejected,
  // configuration port
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [owbm_pkg::AddrW-1:0] paddr,
  input  logic [owbm_pkg::DataW-1:0] pwdata,
  output logic [owbm_pkg::DataW-1:0] prdata,
  output logic                     pready
);
  import owbm_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_RST_LOW  = 3'd1,
    PH_RST_WAIT = 3'd2,
    PH_RST_TAIL = 3'd3,
    PH_WR_LOW   = 3'd4,
    PH_WR_HOLD  = 3'd5,
    PH_RECOVER  = 3'd6,
    PH_RD_SLOT  = 3'd7
  } phase_t;

  tick_t  cfg_reg [NumRegs];
  phase_t phase, phase_next;
  tick_t  tick_count, tick_count_next;
  logic [2:0] bit_index, bit_index_next;
  byte_t  shift_reg, shift_reg_next;
  logic   presence_flag, presence_flag_next;
  logic   mode_read, mode_read_next;
  byte_t  read_latch, read_latch_next;

  logic   drive_next, done_next, rej_next;
  logic   in_accept;
  logic   cfg_write;
  tick_t  tick_inc;
  tick_t  rd_low, rd_sample;

  assign in_stall  = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;
  assign prdata    = {{(DataW-TickW){1'b0}}, cfg_reg[paddr[AddrW-1:2]]};

  assign rd_low    = eff_ticks(cfg_reg[RegReadLow]);
  assign rd_sample = (cfg_reg[RegReadSample] < rd_low) ? rd_low : cfg_reg[RegReadSample];

  always_comb begin
    phase_next         = phase;
    tick_count_next    = tick_count;
    bit_index_next     = bit_index;
    shift_reg_next     = shift_reg;
    presence_flag_next = presence_flag;
    mode_read_next     = mode_read;
    read_latch_next    = read_latch;
    drive_next         = 1'b0;
    done_next          = 1'b0;
    rej_next           = 1'b0;

    // start a command on this same tick, or flag it if one is running
    if (action != ActTick) begin
      if (phase != PH_IDLE) begin
        rej_next = 1'b1;
      end else begin
        tick_count_next = '0;
        bit_index_next  = '0;
        case (action)
          ActReset: begin
            presence_flag_next = 1'b0;
            phase_next         = PH_RST_LOW;
          end
          ActWrite: begin
            mode_read_next = 1'b0;
            shift_reg_next = write_byte;
            phase_next     = PH_WR_LOW;
          end
          default: begin
            mode_read_next = 1'b1;
            shift_reg_next = '0;
            phase_next     = PH_RD_SLOT;
          end
        endcase
      end
    end

    tick_inc = tick_count_next + tick_t'(1);

    case (phase_next)
      PH_RST_LOW: begin
        drive_next      = 1'b1;
        tick_count_next = tick_inc;
        if (tick_inc >= eff_ticks(cfg_reg[RegResetLow])) begin
          tick_count_next = '0;
          phase_next      = PH_RST_WAIT;
        end
      end
      PH_RST_WAIT: begin
        tick_count_next = tick_inc;
        if (tick_inc >= eff_ticks(cfg_reg[RegPresWait])) begin
          tick_count_next    = '0;
          presence_flag_next = !line_level;
          phase_next         = PH_RST_TAIL;
        end
      end
      PH_RST_TAIL: begin
        tick_count_next = tick_inc;
        if (tick_inc >= eff_ticks(cfg_reg[RegResetTail])) begin
          tick_count_next = '0;
          phase_next      = PH_IDLE;
          done_next       = 1'b1;
        end
      end
      PH_WR_LOW: begin
        drive_next      = 1'b1;
        tick_count_next = tick_inc;
        if (tick_inc >= eff_ticks(cfg_reg[RegSlotLow])) begin
          tick_count_next = '0;
          phase_next      = PH_WR_HOLD;
        end
      end
      PH_WR_HOLD: begin
        drive_next      = !shift_reg_next[0];
        tick_count_next = tick_inc;
        if (tick_inc >= eff_ticks(cfg_reg[RegSlotHold])) begin
          tick_count_next = '0;
          shift_reg_next  = {1'b0, shift_reg_next[ByteW-1:1]};
          phase_next      = PH_RECOVER;
        end
      end
      PH_RD_SLOT: begin
        drive_next = (tick_count_next < rd_low);
        if (tick_count_next >= rd_sample) begin
          // shift the sampled bit in from the top
          shift_reg_next  = {line_level, shift_reg_next[ByteW-1:1]};
          tick_count_next = '0;
          phase_next      = PH_RECOVER;
        end else begin
          tick_count_next = tick_inc;
        end
      end
      PH_RECOVER: begin
        tick_count_next = tick_inc;
        if (tick_inc >= eff_ticks(cfg_reg[RegRecovery])) begin
          tick_count_next = '0;
          if (bit_index_next == 3'd7) begin
            bit_index_next = '0;
            phase_next     = PH_IDLE;
            done_next      = 1'b1;
            if (mode_read_next) begin
              read_latch_next = shift_reg_next;
            end
          end else begin
            bit_index_next = bit_index_next + 3'd1;
            phase_next     = mode_read_next ? PH_RD_SLOT : PH_WR_LOW;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NumRegs; i++) begin
        cfg_reg[i] <= RegResetVal[i];
      end
    end else if (cfg_write) begin
      cfg_reg[paddr[AddrW-1:2]] <= pwdata[TickW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      tick_count    <= '0;
      bit_index     <= '0;
      shift_reg     <= '0;
      presence_flag <= 1'b0;
      mode_read     <= 1'b0;
      read_latch    <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (in_accept) begin
        phase         <= phase_next;
        tick_count    <= tick_count_next;
        bit_index     <= bit_index_next;
        shift_reg     <= shift_reg_next;
        presence_flag <= presence_flag_next;
        mode_read     <= mode_read_next;
        read_latch    <= read_latch_next;
        out_valid     <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result beat payload; holds while stalled since no beat is accepted then
  always_ff @(posedge clk) begin
    if (in_accept) begin
      drive_low     <= drive_next;
      busy_res      <= (phase_next != PH_IDLE);
      done_res      <= done_next;
      presence_seen <= presence_flag_next;
      read_data     <= read_latch_next;
      rejected      <= rej_next;
    end
  end

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> !busy_res)
    else $error("done reported while still busy");

  // a command that is refused can only leave idle behind by finishing
  a_reject_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && rejected && !done_res |-> busy_res)
    else $error("reject reported with no command running");

  a_idle_counters: assert property (@(posedge clk) disable iff (rst)
    phase == PH_IDLE |-> tick_count == '0 && bit_index == '0)
    else $error("counters not cleared in idle");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with empty output register");

endmodule
